### src/usm_pkg.sv
// Shared types, constants and the arctangent table of the sphere tessellator.
`timescale 1ns / 1ps
package usm_pkg;

	localparam int MaxStacks   = 256;
	localparam int MaxSectors  = 256;
	localparam int CordicSteps = 16;
	localparam int AtanLen     = 24;
	localparam int StepW       = $clog2(AtanLen);

	localparam int CntW     = 9;
	localparam int CornerW  = 17;
	localparam int RowW     = 19;
	localparam int AngW     = 32;
	localparam int CorW     = 33;
	localparam int NormW    = 16;
	localparam int PosW     = 23;
	localparam int RadW     = 16;
	localparam int CfgIdxW  = 2;
	localparam int CfgDataW = 16;
	localparam int OneQ14   = 16384;

	// CORDIC start value: 1/gain in Q1.30
	localparam logic signed [CorW-1:0] CordicX0 = 33'sd652032874;

	typedef enum logic [CfgIdxW-1:0] {
		REG_RADIUS  = 2'd0,
		REG_SECTORS = 2'd1,
		REG_STACKS  = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		CMD_VERTEX = 1'b0,
		CMD_QUAD   = 1'b1
	} cmd_t;

	typedef enum logic {
		KIND_VERTEX = 1'b0,
		KIND_TRI    = 1'b1
	} kind_t;

	// control word traveling beside the arithmetic
	typedef struct packed {
		logic               valid;
		logic               kind;
		logic               last;
		logic [CornerW-1:0] ca;
		logic [CornerW-1:0] cb;
		logic [CornerW-1:0] cc;
	} side_t;

	typedef struct packed {
		logic [CntW-1:0] rem;
		logic [AngW-1:0] lo;
		logic [AngW-1:0] q;
	} div_lane_t;

	typedef struct packed {
		logic [1:0]             quad;
		logic signed [CorW-1:0] x;
		logic signed [CorW-1:0] y;
		logic signed [AngW-1:0] z;
	} cor_lane_t;

	// arctangent of 2^-k in turns * 2^32
	function automatic logic signed [AngW-1:0] atan_turn(input logic [StepW-1:0] k);
		logic signed [AngW-1:0] a;
		case (k)
			5'd0:    a = 32'sh20000000;
			5'd1:    a = 32'sh12E4051D;
			5'd2:    a = 32'sh09FB385B;
			5'd3:    a = 32'sh051111D4;
			5'd4:    a = 32'sh028B0D43;
			5'd5:    a = 32'sh0145D7E1;
			5'd6:    a = 32'sh00A2F61E;
			5'd7:    a = 32'sh00517C55;
			5'd8:    a = 32'sh0028BE53;
			5'd9:    a = 32'sh00145F2E;
			5'd10:   a = 32'sh000A2F98;
			5'd11:   a = 32'sh000517CC;
			5'd12:   a = 32'sh00028BE6;
			5'd13:   a = 32'sh000145F3;
			5'd14:   a = 32'sh0000A2F9;
			5'd15:   a = 32'sh0000517C;
			5'd16:   a = 32'sh000028BE;
			5'd17:   a = 32'sh0000145F;
			5'd18:   a = 32'sh00000A2F;
			5'd19:   a = 32'sh00000517;
			5'd20:   a = 32'sh0000028B;
			5'd21:   a = 32'sh00000145;
			5'd22:   a = 32'sh000000A2;
			5'd23:   a = 32'sh00000051;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

### src/usm_div_cell.sv
// One quotient bit of the two angle dividers (phi and theta lanes).
`timescale 1ns / 1ps
module usm_div_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  usm_pkg::side_t            side_in,
	input  usm_pkg::div_lane_t        phi_in,
	input  usm_pkg::div_lane_t        theta_in,
	input  logic [usm_pkg::CntW-1:0]  stk_div,
	input  logic [usm_pkg::CntW-1:0]  sec_div,
	output usm_pkg::side_t            side_out,
	output usm_pkg::div_lane_t        phi_out,
	output usm_pkg::div_lane_t        theta_out
);
	import usm_pkg::*;

	side_t     side_q;
	div_lane_t phi_q;
	div_lane_t theta_q;

	// restoring step: shift in next dividend bit, subtract if it fits
	function automatic div_lane_t div_step(input div_lane_t l, input logic [CntW-1:0] d);
		logic [CntW:0] trial;
		div_lane_t     r;
		trial = {l.rem, l.lo[AngW-1]};
		r     = l;
		r.lo  = {l.lo[AngW-2:0], 1'b0};
		if (trial >= {1'b0, d}) begin
			r.rem = CntW'(trial - {1'b0, d});
			r.q   = {l.q[AngW-2:0], 1'b1};
		end else begin
			r.rem = CntW'(trial);
			r.q   = {l.q[AngW-2:0], 1'b0};
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= '0;
		end else begin
			side_q <= side_in;
		end
	end

	always_ff @(posedge clk) begin
		phi_q   <= div_step(phi_in, stk_div);
		theta_q <= div_step(theta_in, sec_div);
	end

	assign side_out  = side_q;
	assign phi_out   = phi_q;
	assign theta_out = theta_q;

endmodule

### src/usm_cordic_cell.sv
// One CORDIC rotation step for the phi and theta lanes.
`timescale 1ns / 1ps
module usm_cordic_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [usm_pkg::StepW-1:0]  step,
	input  usm_pkg::side_t             side_in,
	input  usm_pkg::cor_lane_t         phi_in,
	input  usm_pkg::cor_lane_t         theta_in,
	output usm_pkg::side_t             side_out,
	output usm_pkg::cor_lane_t         phi_out,
	output usm_pkg::cor_lane_t         theta_out
);
	import usm_pkg::*;

	side_t     side_q;
	cor_lane_t phi_q;
	cor_lane_t theta_q;

	function automatic cor_lane_t rot(input cor_lane_t l, input logic [StepW-1:0] k);
		logic signed [CorW-1:0] dx;
		logic signed [CorW-1:0] dy;
		logic signed [AngW-1:0] a;
		cor_lane_t              r;
		dx = $signed(l.y) >>> k;
		dy = $signed(l.x) >>> k;
		a  = atan_turn(k);
		r  = l;
		if (!l.z[AngW-1]) begin
			r.x = $signed(l.x) - dx;
			r.y = $signed(l.y) + dy;
			r.z = $signed(l.z) - a;
		end else begin
			r.x = $signed(l.x) + dx;
			r.y = $signed(l.y) - dy;
			r.z = $signed(l.z) + a;
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= '0;
		end else begin
			side_q <= side_in;
		end
	end

	always_ff @(posedge clk) begin
		phi_q   <= rot(phi_in, step);
		theta_q <= rot(theta_in, step);
	end

	assign side_out  = side_q;
	assign phi_out   = phi_q;
	assign theta_out = theta_q;

endmodule

### src/usm_finish.sv
// Quadrant fold, rounding, normal products and radius scaling, five stages.
`timescale 1ns / 1ps
module usm_finish (
	input  logic                              clk,
	input  logic                              arst_n,
	input  usm_pkg::side_t                    side_in,
	input  usm_pkg::cor_lane_t                phi_in,
	input  usm_pkg::cor_lane_t                theta_in,
	input  logic [usm_pkg::RadW-1:0]          radius,
	output logic                              strobe,
	output logic                              kind,
	output logic signed [usm_pkg::PosW-1:0]   pos_x,
	output logic signed [usm_pkg::PosW-1:0]   pos_y,
	output logic signed [usm_pkg::PosW-1:0]   pos_z,
	output logic signed [usm_pkg::NormW-1:0]  norm_x,
	output logic signed [usm_pkg::NormW-1:0]  norm_y,
	output logic signed [usm_pkg::NormW-1:0]  norm_z,
	output logic [usm_pkg::CornerW-1:0]       corner_a,
	output logic [usm_pkg::CornerW-1:0]       corner_b,
	output logic [usm_pkg::CornerW-1:0]       corner_c,
	output logic                              last
);
	import usm_pkg::*;

	localparam int ProdW = 2 * NormW;
	localparam int PosPW = NormW + RadW + 1;

	side_t side_s1, side_s2, side_s3, side_s4, side_s5;
	logic signed [NormW-1:0] cp_s1, sp_s1, ct_s1, st_s1;
	logic signed [ProdW-1:0] px_s2, pz_s2;
	logic signed [NormW-1:0] ny_s2;
	logic signed [NormW-1:0] nx_s3, ny_s3, nz_s3;
	logic signed [PosPW-1:0] qx_s4, qy_s4, qz_s4;
	logic signed [NormW-1:0] nx_s4, ny_s4, nz_s4;
	logic signed [PosW-1:0]  px_s5, py_s5, pz_s5;
	logic signed [NormW-1:0] nx_s5, ny_s5, nz_s5;

	function automatic logic signed [NormW-1:0] clamp_unit(input logic signed [ProdW:0] v);
		logic signed [NormW-1:0] r;
		if (v > OneQ14) begin
			r = NormW'(OneQ14);
		end else if (v < -OneQ14) begin
			r = NormW'(-OneQ14);
		end else begin
			r = NormW'(v);
		end
		return r;
	endfunction

	// Q1.30 to Q1.14 with round half up
	function automatic logic signed [NormW-1:0] rnd16(input logic signed [CorW-1:0] v);
		logic signed [CorW:0] t;
		t = $signed({v[CorW-1], v}) + $signed((CorW+1)'(32768));
		return clamp_unit((ProdW+1)'(t >>> 16));
	endfunction

	function automatic logic signed [NormW-1:0] rnd14(input logic signed [ProdW-1:0] v);
		logic signed [ProdW:0] t;
		t = $signed({v[ProdW-1], v}) + $signed((ProdW+1)'(8192));
		return clamp_unit(t >>> 14);
	endfunction

	function automatic logic signed [PosW-1:0] rnd8(input logic signed [PosPW-1:0] v);
		logic signed [PosPW:0] t;
		logic signed [PosPW:0] s;
		t = $signed({v[PosPW-1], v}) + $signed((PosPW+1)'(128));
		s = t >>> 8;
		return s[PosW-1:0];
	endfunction

	// quadrant fold: (c,s), (-s,c), (-c,-s), (s,-c)
	function automatic cor_lane_t fold(input cor_lane_t l);
		cor_lane_t r;
		r = l;
		case (l.quad)
			2'd0: begin r.x = l.x;              r.y = l.y;              end
			2'd1: begin r.x = -$signed(l.y);    r.y = l.x;              end
			2'd2: begin r.x = -$signed(l.x);    r.y = -$signed(l.y);    end
			default: begin r.x = l.y;           r.y = -$signed(l.x);    end
		endcase
		return r;
	endfunction

	cor_lane_t phi_f, theta_f;
	assign phi_f   = fold(phi_in);
	assign theta_f = fold(theta_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
			side_s2 <= '0;
			side_s3 <= '0;
			side_s4 <= '0;
			side_s5 <= '0;
		end else begin
			side_s1 <= side_in;
			side_s2 <= side_s1;
			side_s3 <= side_s2;
			side_s4 <= side_s3;
			side_s5 <= side_s4;
		end
	end

	always_ff @(posedge clk) begin
		cp_s1 <= rnd16(phi_f.x);
		sp_s1 <= rnd16(phi_f.y);
		ct_s1 <= rnd16(theta_f.x);
		st_s1 <= rnd16(theta_f.y);

		px_s2 <= sp_s1 * ct_s1;
		pz_s2 <= sp_s1 * st_s1;
		ny_s2 <= cp_s1;

		nx_s3 <= rnd14(px_s2);
		nz_s3 <= rnd14(pz_s2);
		ny_s3 <= ny_s2;

		qx_s4 <= nx_s3 * $signed({1'b0, radius});
		qy_s4 <= ny_s3 * $signed({1'b0, radius});
		qz_s4 <= nz_s3 * $signed({1'b0, radius});
		nx_s4 <= nx_s3;
		ny_s4 <= ny_s3;
		nz_s4 <= nz_s3;

		px_s5 <= rnd8(qx_s4);
		py_s5 <= rnd8(qy_s4);
		pz_s5 <= rnd8(qz_s4);
		nx_s5 <= nx_s4;
		ny_s5 <= ny_s4;
		nz_s5 <= nz_s4;
	end

	logic is_vtx;
	assign is_vtx = (side_s5.kind == KIND_VERTEX);

	assign strobe   = side_s5.valid;
	assign kind     = side_s5.kind;
	assign last     = side_s5.last;
	assign pos_x    = is_vtx ? px_s5 : '0;
	assign pos_y    = is_vtx ? py_s5 : '0;
	assign pos_z    = is_vtx ? pz_s5 : '0;
	assign norm_x   = is_vtx ? nx_s5 : '0;
	assign norm_y   = is_vtx ? ny_s5 : '0;
	assign norm_z   = is_vtx ? nz_s5 : '0;
	assign corner_a = is_vtx ? '0 : side_s5.ca;
	assign corner_b = is_vtx ? '0 : side_s5.cb;
	assign corner_c = is_vtx ? '0 : side_s5.cc;

endmodule

### src/uv_sphere_mesh_generator.sv
// Top level of the UV sphere tessellator: command entry, cell chains, finish stages.
`timescale 1ns / 1ps
// Usage:
//  - Command channel: a word (command, stack_index, sector_index) is taken at
//    a rising edge with start high and busy low. Vertex commands ask for the
//    vertex at (stack, sector); quad commands ask for the triangles below it.
//  - Result channel: strobe marks a result word for exactly one cycle; the
//    receiver cannot stall it. last flags the final word of a command.
//  - Config port: cfg_we/cfg_index/cfg_data write radius (0), sector_count
//    (1), stack_count (2); write only while no command is in flight.
//  - Pipeline: from acceptance to the result word, a command passes the entry
//    register, the 32-cell angle divider chain (one quotient bit per cell),
//    the 16-cell CORDIC chain and five finish stages.
//  - Throughput: one command per cycle while busy is low. A quad that gives
//    two triangles raises busy for the one following cycle, while its second
//    triangle enters the chain; so the result side never sees more than one
//    word per cycle.
//  - Out-of-range commands and bad geometry flow through without a strobe.
//  - Reset: asynchronous, clears the control words of the chains and loads
//    radius 1.0, 32 sectors, 16 stacks. No clearing pass is needed.
module uv_sphere_mesh_generator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                command,
	input  logic [usm_pkg::CntW-1:0]            stack_index,
	input  logic [usm_pkg::CntW-1:0]            sector_index,
	input  logic                                cfg_we,
	input  logic [usm_pkg::CfgIdxW-1:0]         cfg_index,
	input  logic [usm_pkg::CfgDataW-1:0]        cfg_data,
	output logic                                strobe,
	output logic                                kind,
	output logic signed [usm_pkg::PosW-1:0]     pos_x,
	output logic signed [usm_pkg::PosW-1:0]     pos_y,
	output logic signed [usm_pkg::PosW-1:0]     pos_z,
	output logic signed [usm_pkg::NormW-1:0]    norm_x,
	output logic signed [usm_pkg::NormW-1:0]    norm_y,
	output logic signed [usm_pkg::NormW-1:0]    norm_z,
	output logic [usm_pkg::CornerW-1:0]         corner_a,
	output logic [usm_pkg::CornerW-1:0]         corner_b,
	output logic [usm_pkg::CornerW-1:0]         corner_c,
	output logic                                last
);
	import usm_pkg::*;

	// configuration registers
	logic [RadW-1:0] radius_q;
	logic [CntW-1:0] secs_q;
	logic [CntW-1:0] stks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RadW'(256);
			secs_q   <= CntW'(32);
			stks_q   <= CntW'(16);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RADIUS:  radius_q <= cfg_data;
				REG_SECTORS: secs_q   <= cfg_data[CntW-1:0];
				REG_STACKS:  stks_q   <= cfg_data[CntW-1:0];
				default:     ;
			endcase
		end
	end

	// ---------------- command entry ----------------
	logic accept;
	logic geom_ok, vert_ok, quad_ok, has_up, has_lo;
	logic [RowW-1:0] row, nxt, jj;
	logic [CornerW-1:0] up_a, up_b, up_c, lo_a, lo_b, lo_c;

	// pending lower triangle of a two-triangle quad
	logic               pend_q;
	logic [CornerW-1:0] pend_a_q, pend_b_q, pend_c_q;

	assign busy   = pend_q;
	assign accept = start && !busy;

	assign geom_ok = (secs_q != '0) && (secs_q <= CntW'(MaxSectors))
		&& (stks_q != '0) && (stks_q <= CntW'(MaxStacks));
	assign vert_ok = geom_ok && (stack_index <= stks_q) && (sector_index <= secs_q);
	assign quad_ok = geom_ok && (stack_index < stks_q) && (sector_index < secs_q);
	assign has_up  = (stack_index != '0);
	assign has_lo  = (stack_index != (stks_q - CntW'(1)));

	// vertex numbering: i * (sectors + 1) + j
	assign row = RowW'(stack_index) * (RowW'(secs_q) + RowW'(1));
	assign nxt = row + RowW'(secs_q) + RowW'(1);
	assign jj  = RowW'(sector_index);

	assign up_a = CornerW'(row + jj);
	assign up_b = CornerW'(nxt + jj);
	assign up_c = CornerW'(row + jj + RowW'(1));
	assign lo_a = CornerW'(row + jj + RowW'(1));
	assign lo_b = CornerW'(nxt + jj);
	assign lo_c = CornerW'(nxt + jj + RowW'(1));

	side_t side_in;
	always_comb begin
		side_in = '0;
		if (pend_q) begin
			side_in.valid = 1'b1;
			side_in.kind  = KIND_TRI;
			side_in.last  = 1'b1;
			side_in.ca    = pend_a_q;
			side_in.cb    = pend_b_q;
			side_in.cc    = pend_c_q;
		end else if (accept) begin
			if (command == CMD_VERTEX) begin
				side_in.valid = vert_ok;
				side_in.kind  = KIND_VERTEX;
				side_in.last  = 1'b1;
			end else if (has_up) begin
				side_in.valid = quad_ok;
				side_in.kind  = KIND_TRI;
				side_in.last  = !has_lo;
				side_in.ca    = up_a;
				side_in.cb    = up_b;
				side_in.cc    = up_c;
			end else begin
				side_in.valid = quad_ok && has_lo;
				side_in.kind  = KIND_TRI;
				side_in.last  = 1'b1;
				side_in.ca    = lo_a;
				side_in.cb    = lo_b;
				side_in.cc    = lo_c;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else begin
			pend_q <= accept && (command == CMD_QUAD) && quad_ok && has_up && has_lo;
		end
	end

	always_ff @(posedge clk) begin
		pend_a_q <= lo_a;
		pend_b_q <= lo_b;
		pend_c_q <= lo_c;
	end

	// divider seeds: phi = i*2^31/stacks, theta = j*2^32/sectors mod 2^32
	div_lane_t phi_seed, theta_seed;
	always_comb begin
		phi_seed     = '0;
		phi_seed.rem = {1'b0, stack_index[CntW-1:1]};
		phi_seed.lo  = {stack_index[0], {(AngW-1){1'b0}}};
		theta_seed   = '0;
		// j equal to the sector count wraps to angle zero
		theta_seed.rem = (sector_index == secs_q) ? '0 : sector_index;
	end

	side_t     side_s0;
	div_lane_t phi_s0, theta_s0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s0 <= '0;
		end else begin
			side_s0 <= side_in;
		end
	end

	always_ff @(posedge clk) begin
		phi_s0   <= phi_seed;
		theta_s0 <= theta_seed;
	end

	// ---------------- divider chain ----------------
	side_t     dv_side  [AngW+1];
	div_lane_t dv_phi   [AngW+1];
	div_lane_t dv_theta [AngW+1];

	assign dv_side[0]  = side_s0;
	assign dv_phi[0]   = phi_s0;
	assign dv_theta[0] = theta_s0;

	for (genvar g = 0; g < AngW; g++) begin : g_div
		usm_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.side_in   (dv_side[g]),
			.phi_in    (dv_phi[g]),
			.theta_in  (dv_theta[g]),
			.stk_div   (stks_q),
			.sec_div   (secs_q),
			.side_out  (dv_side[g+1]),
			.phi_out   (dv_phi[g+1]),
			.theta_out (dv_theta[g+1])
		);
	end

	// ---------------- CORDIC chain ----------------
	side_t     cr_side  [CordicSteps+1];
	cor_lane_t cr_phi   [CordicSteps+1];
	cor_lane_t cr_theta [CordicSteps+1];

	// top two angle bits pick the quadrant, the rest is rotated
	assign cr_phi[0].quad   = dv_phi[AngW].q[AngW-1:AngW-2];
	assign cr_phi[0].x      = CordicX0;
	assign cr_phi[0].y      = '0;
	assign cr_phi[0].z      = {2'b00, dv_phi[AngW].q[AngW-3:0]};
	assign cr_theta[0].quad = dv_theta[AngW].q[AngW-1:AngW-2];
	assign cr_theta[0].x    = CordicX0;
	assign cr_theta[0].y    = '0;
	assign cr_theta[0].z    = {2'b00, dv_theta[AngW].q[AngW-3:0]};
	assign cr_side[0] = dv_side[AngW];

	for (genvar g = 0; g < CordicSteps; g++) begin : g_cor
		usm_cordic_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.step      (StepW'(g)),
			.side_in   (cr_side[g]),
			.phi_in    (cr_phi[g]),
			.theta_in  (cr_theta[g]),
			.side_out  (cr_side[g+1]),
			.phi_out   (cr_phi[g+1]),
			.theta_out (cr_theta[g+1])
		);
	end

	// ---------------- finish stages ----------------
	usm_finish u_finish (
		.clk      (clk),
		.arst_n   (arst_n),
		.side_in  (cr_side[CordicSteps]),
		.phi_in   (cr_phi[CordicSteps]),
		.theta_in (cr_theta[CordicSteps]),
		.radius   (radius_q),
		.strobe   (strobe),
		.kind     (kind),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.pos_z    (pos_z),
		.norm_x   (norm_x),
		.norm_y   (norm_y),
		.norm_z   (norm_z),
		.corner_a (corner_a),
		.corner_b (corner_b),
		.corner_c (corner_c),
		.last     (last)
	);

	// ---------------- checks ----------------
	// the second-triangle slot (busy) is never held in consecutive cycles
	a_busy_one: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("busy held for more than one cycle");

	// first triangle of a pair is followed at once by its partner
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last) |=> (strobe && last && kind == KIND_TRI))
		else $error("triangle pair split");

	// vertex records are single words
	a_vtx_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && kind == KIND_VERTEX) |-> last)
		else $error("vertex record without last");

	// a non-last word only comes from a triangle pair
	a_first_tri: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last) |-> (kind == KIND_TRI))
		else $error("non-last vertex record");

endmodule
